>>> rtl/core/omc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// omc_pkg: shared types for the optimal merge cost block
// Payload structs, controller states and controller/datapath command types.
// ----------------------------------------------------------------------------
package omc_pkg;

	localparam int MaxItemsDef = 1024;
	localparam int ValueW      = 31;
	localparam int TotalW      = 63;
	localparam int KeyW        = 64;

	typedef struct packed {
		logic [ValueW-1:0] value;
		logic              has_value;
		logic              last_item;
	} in_item_t;

	typedef struct packed {
		logic [TotalW-1:0] total_cost;
		logic              overflowed;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INS_CHK,
		ST_PUSH_RD,
		ST_PUSH_CMP,
		ST_MERGE_CHK,
		ST_POP_RD0,
		ST_POP_RDT,
		ST_POP_TAIL,
		ST_POP_RDL,
		ST_POP_RDR,
		ST_POP_CMP,
		ST_SUM,
		ST_OUT
	} state_t;

	// command from controller to datapath
	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD_IN,     // latch input item, open a hole at the tail
		OP_PUSH_RD,     // read parent of the hole
		OP_PUSH_CMP,    // compare with parent, move parent down or settle
		OP_POP_RD0,     // read root
		OP_POP_RDT,     // take root, read tail
		OP_POP_TAIL,    // tail becomes the key sifted from the root
		OP_POP_RDL,
		OP_POP_RDR,
		OP_POP_CMP,
		OP_PUSH_SUM,    // sum of the popped pair goes in at the tail
		OP_CLEAR
	} op_t;

	typedef struct packed {
		logic has_in;
		logic last_in;
		logic cnt_gt1;
		logic sift_done;   // sift loop finished this cycle
	} dp_status_t;

endpackage
`default_nettype wire

>>> rtl/core/omc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// omc_datapath: heap memory, index registers and merge accumulator
// Carries out single heap steps as commanded by the controller.
// ----------------------------------------------------------------------------
module omc_datapath
	import omc_pkg::*;
#(
	parameter int MaxItems = MaxItemsDef
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire op_t        op,
	input  wire in_item_t   in_data,
	output dp_status_t      status,
	output out_item_t       result
);
	localparam int AW = (MaxItems > 1) ? $clog2(MaxItems) : 1;
	localparam int CW = $clog2(MaxItems + 1);
	localparam int XW = AW + 2;

	logic [KeyW-1:0] mem [MaxItems];
	logic [KeyW-1:0] rd_q;
	logic            we;
	logic [AW-1:0]   wa, ra;
	logic [KeyW-1:0] wd;

	logic [CW-1:0]   cnt_q, cnt_m1;
	logic [AW-1:0]   idx_q, idx_m1, parent;
	logic [KeyW-1:0] cur_q, lv_q, top_q, first_q, total_q;
	logic [KeyW-1:0] sum_w, in_key, best_l;
	logic            drop_q, has_q, last_q;
	logic [XW-1:0]   lft, rgt, cnt_x;
	logic            lft_ok, rgt_ok, full;
	logic            push_done, take_l, take_r, pop_done;

	assign in_key = {{(KeyW-ValueW){1'b0}}, in_data.value};
	assign sum_w  = first_q + top_q;
	assign cnt_m1 = cnt_q - 1'b1;
	assign idx_m1 = idx_q - 1'b1;
	assign parent = idx_m1 >> 1;
	assign full   = (cnt_q == CW'(MaxItems));

	assign lft   = {1'b0, idx_q, 1'b1};
	assign rgt   = lft + 1'b1;
	assign cnt_x = XW'(cnt_q);
	assign lft_ok = (lft < cnt_x);
	assign rgt_ok = (rgt < cnt_x);

	// sift up settles at the root or under a parent that is not larger
	assign push_done = (idx_q == '0) || (rd_q <= cur_q);
	// sift down: left child in lv_q, right child arriving in rd_q
	assign take_l   = lft_ok && (lv_q < cur_q);
	assign best_l   = take_l ? lv_q : cur_q;
	assign take_r   = rgt_ok && (rd_q < best_l);
	assign pop_done = !take_l && !take_r;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_q <= mem[ra];
	end

	always_comb begin
		we = 1'b0; wa = idx_q; wd = cur_q; ra = idx_q;
		case (op)
			OP_PUSH_RD: ra = parent;
			OP_PUSH_CMP: begin
				we = 1'b1;
				wd = push_done ? cur_q : rd_q;
			end
			OP_POP_RD0: ra = '0;
			OP_POP_RDT: ra = cnt_m1[AW-1:0];
			OP_POP_RDL: ra = lft[AW-1:0];
			OP_POP_RDR: ra = rgt[AW-1:0];
			OP_POP_CMP: begin
				we = 1'b1;
				wd = pop_done ? cur_q : (take_r ? rd_q : lv_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0; idx_q <= '0; total_q <= '0; drop_q <= 1'b0;
			has_q <= 1'b0; last_q <= 1'b0;
			cur_q <= '0; lv_q <= '0; top_q <= '0; first_q <= '0;
		end else begin
			case (op)
				OP_LOAD_IN: begin
					last_q <= in_data.last_item;
					has_q  <= in_data.has_value && !full;
					idx_q  <= cnt_q[AW-1:0];
					cur_q  <= in_key;
					if (in_data.has_value) begin
						if (full) drop_q <= 1'b1;
						else cnt_q <= cnt_q + 1'b1;
					end
				end
				OP_PUSH_CMP: if (!push_done) idx_q <= parent;
				// keeps the value of the earlier pop of the pair
				OP_POP_RD0: first_q <= top_q;
				OP_POP_RDT: begin
					top_q <= rd_q;
					cnt_q <= cnt_m1;
				end
				OP_POP_TAIL: begin
					cur_q <= rd_q;
					idx_q <= '0;
				end
				OP_POP_RDR: lv_q <= rd_q;
				OP_POP_CMP: if (!pop_done) idx_q <= take_r ? rgt[AW-1:0] : lft[AW-1:0];
				OP_PUSH_SUM: begin
					cur_q   <= sum_w;
					total_q <= total_q + sum_w;
					idx_q   <= cnt_q[AW-1:0];
					cnt_q   <= cnt_q + 1'b1;
				end
				OP_CLEAR: begin
					cnt_q <= '0; total_q <= '0; drop_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	assign status = '{
		has_in:    has_q,
		last_in:   last_q,
		cnt_gt1:   (cnt_q > CW'(1)),
		sift_done: (op == OP_POP_CMP) ? pop_done : push_done
	};

	assign result = '{total_cost: total_q[TotalW-1:0], overflowed: drop_q};
endmodule
`default_nettype wire

>>> rtl/core/omc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// omc_ctrl: sequencer for heap insert, removal and merge loop
// Issues one datapath command per cycle and drives the handshakes.
// ----------------------------------------------------------------------------
module omc_ctrl
	import omc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  wire logic       out_ready,
	input  wire dp_status_t status,
	output op_t             op
);
	state_t state_q, state_d;
	logic   second_q, second_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE; second_q <= 1'b0;
		end else begin
			state_q <= state_d; second_q <= second_d;
		end
	end

	always_comb begin
		state_d = state_q; second_d = second_q; op = OP_NOP;
		in_ready = 1'b0; out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					op = OP_LOAD_IN;
					state_d = ST_INS_CHK;
				end
			end
			ST_INS_CHK: begin
				if (status.has_in) begin
					op = OP_PUSH_RD; state_d = ST_PUSH_CMP;
				end else if (status.last_in) state_d = ST_MERGE_CHK;
				else state_d = ST_IDLE;
			end
			ST_PUSH_RD: begin
				op = OP_PUSH_RD; state_d = ST_PUSH_CMP;
			end
			ST_PUSH_CMP: begin
				op = OP_PUSH_CMP;
				if (!status.sift_done) state_d = ST_PUSH_RD;
				else if (status.last_in) state_d = ST_MERGE_CHK;
				else state_d = ST_IDLE;
			end
			ST_MERGE_CHK: begin
				second_d = 1'b0;
				if (status.cnt_gt1) state_d = ST_POP_RD0;
				else state_d = ST_OUT;
			end
			ST_POP_RD0: begin
				op = OP_POP_RD0; state_d = ST_POP_RDT;
			end
			ST_POP_RDT: begin
				op = OP_POP_RDT; state_d = ST_POP_TAIL;
			end
			ST_POP_TAIL: begin
				op = OP_POP_TAIL; state_d = ST_POP_RDL;
			end
			ST_POP_RDL: begin
				op = OP_POP_RDL; state_d = ST_POP_RDR;
			end
			ST_POP_RDR: begin
				op = OP_POP_RDR; state_d = ST_POP_CMP;
			end
			ST_POP_CMP: begin
				op = OP_POP_CMP;
				if (!status.sift_done) state_d = ST_POP_RDL;
				else if (second_q) state_d = ST_SUM;
				else begin
					second_d = 1'b1; state_d = ST_POP_RD0;
				end
			end
			ST_SUM: begin
				op = OP_PUSH_SUM; second_d = 1'b0; state_d = ST_PUSH_RD;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					op = OP_CLEAR; state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

>>> rtl/core/optimal_merge_cost.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// optimal_merge_cost: Huffman / optimal-merge cost of a set of values
// Values are inserted in a min-heap; the end marker runs the merge loop.
// ----------------------------------------------------------------------------
// channel | signals                 | payload
// in      | in_valid / in_ready     | in_item_t (value, has_value, last_item)
// out     | out_valid / out_ready   | out_item_t (total_cost, overflowed)
//
// an insert reads the parent and compares per heap level sifted, one read
// at a time on the single memory read port. the merge loop pops twice and
// pushes once per step: a pop reads the root and the tail, then the left and
// right child and compares per level; a push reads and compares per level.
// no reset pass: a fill count tracks the heap. input is taken only when
// idle: it is stalled while an insert sifts, merging or a result waits.
// ----------------------------------------------------------------------------
module optimal_merge_cost
	import omc_pkg::*;
#(
	parameter int MaxItems = MaxItemsDef
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_item_t  in_data,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_item_t      out_data
);
	op_t        op;
	dp_status_t status;

	omc_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
		.status, .op
	);

	omc_datapath #(.MaxItems(MaxItems)) u_dp (
		.clk, .arst_n, .op, .in_data, .status, .result(out_data)
	);
endmodule
`default_nettype wire

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for optimal_merge_cost
// Streams value sets into the block with random idling on both channels. An
// internal sorted-queue model predicts each merge cost, and results are checked in order.
// ----------------------------------------------------------------------------
module tb;
	import omc_pkg::*;

	localparam int MaxItems = MaxItemsDef;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_data;

	optimal_merge_cost #(.MaxItems(MaxItems)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always #6 clk = ~clk;

	// predictor state: the values held for the current set
	logic [63:0] set_vals[$];
	logic        set_dropped = 1'b0;
	out_item_t   cost_q[$];
	int          errors = 0;
	int          mismatches = 0;
	bit          quiet = 1'b0;      // no idling in the last part of the run
	bit          hold_long = 1'b0;  // long receiver hold-off request

	// merge cost by repeated removal of the two smallest entries
	function automatic logic [62:0] merge_cost(input logic [63:0] vals[$]);
		logic [63:0] q[$];
		logic [63:0] a, b, acc;
		q = vals;
		acc = '0;
		while (q.size() > 1) begin
			q.sort();
			a = q.pop_front();
			b = q.pop_front();
			acc += a + b;
			q.push_back(a + b);
		end
		return acc[62:0];
	endfunction

	function automatic void predict(input in_item_t it);
		out_item_t r;
		if (it.has_value) begin
			if (set_vals.size() < MaxItems) set_vals.push_back({33'd0, it.value});
			else set_dropped = 1'b1;
		end
		if (it.last_item) begin
			r.total_cost = merge_cost(set_vals);
			r.overflowed = set_dropped;
			cost_q.push_back(r);
			set_vals = {};
			set_dropped = 1'b0;
		end
	endfunction

	// send one item, with an optional random gap before it
	task automatic send(input in_item_t it);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 8);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict(it);
	endtask

	function automatic in_item_t mk(input logic [30:0] v, input bit hv, input bit li);
		in_item_t it;
		it.value = v; it.has_value = hv; it.last_item = li;
		return it;
	endfunction

	function automatic logic [30:0] rand_val();
		case ($urandom_range(0, 3))
			0: return 31'($urandom_range(0, 15));
			1: return 31'h7fffffff - 31'($urandom_range(0, 3));
			default: return 31'($urandom);
		endcase
	endfunction

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			if (hold_long) begin
				out_ready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_long = 1'b0;
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				n = $urandom_range(1, 8);
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
		end
	end

	// checker
	always @(posedge clk) begin
		out_item_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			if (cost_q.size() == 0) begin
				errors++;
				mismatches++;
				if (mismatches <= 10) $display("unexpected transfer: %h", out_data);
			end else begin
				exp_r = cost_q.pop_front();
				if (out_data.total_cost !== exp_r.total_cost
						|| out_data.overflowed !== exp_r.overflowed) begin
					errors++;
					mismatches++;
					if (mismatches <= 10)
						$display("cost mismatch: exp %0d/%b got %0d/%b",
							exp_r.total_cost, exp_r.overflowed,
							out_data.total_cost, out_data.overflowed);
				end
			end
		end
	end

	typedef struct {
		in_item_t it;
		bit       has_exp;
		logic [62:0] exp_cost;
		bit       exp_ovf;
	} row_t;

	initial begin
		row_t rows[$];
		int sz, items, k;
		out_item_t peek;

		// directed: empty set, single values, extremes, overflow, bare markers
		rows.push_back('{mk(31'd0, 0, 1), 1, 63'd0, 0});
		rows.push_back('{mk(31'h7fffffff, 1, 1), 1, 63'd0, 0});
		rows.push_back('{mk(31'd5, 0, 0), 0, 0, 0});
		rows.push_back('{mk(31'd0, 1, 0), 0, 0, 0});
		rows.push_back('{mk(31'd0, 1, 1), 1, 63'd0, 0});
		rows.push_back('{mk(31'h7fffffff, 1, 0), 0, 0, 0});
		rows.push_back('{mk(31'h7fffffff, 1, 1), 1, 63'hfffffffe, 0});
		rows.push_back('{mk(31'd3, 1, 0), 0, 0, 0});
		rows.push_back('{mk(31'd1, 1, 0), 0, 0, 0});
		rows.push_back('{mk(31'd2, 1, 0), 0, 0, 0});
		rows.push_back('{mk(31'd0, 0, 1), 0, 0, 0});
		for (int i = 0; i < MaxItems + 2; i++)
			rows.push_back('{mk(31'h55555555 ^ 31'(i), 1, i == MaxItems + 1), 0, 0, 0});
		rows.push_back('{mk(31'd0, 0, 1), 1, 63'd0, 0});

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			if (rows[i].has_exp) begin
				peek.total_cost = rows[i].exp_cost;
				peek.overflowed = rows[i].exp_ovf;
			end
			send(rows[i].it);
			if (rows[i].has_exp && cost_q.size() > 0
					&& cost_q[$] !== peek) begin
				errors++;
				$display("directed row %0d: predictor disagrees", i);
			end
		end

		// random sets, mostly small; a long receiver hold-off near the start
		items = rows.size();
		k = 0;
		while (items < 1750) begin
			if (k == 5) hold_long = 1'b1;
			if (k == 40) begin
				in_valid <= 1'b0;
				while (cost_q.size() != 0) @(posedge clk);
			end
			if (items > 1600) quiet = 1'b1;
			sz = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 40)
				: $urandom_range(0, 5);
			for (int j = 0; j < sz; j++) begin
				if ($urandom_range(0, 9) == 0) send(mk(rand_val(), 0, 0));
				else send(mk(rand_val(), 1, j == sz - 1));
				items++;
			end
			if (sz == 0 || $urandom_range(0, 3) == 0) begin
				send(mk(rand_val(), 0, 1));
				items++;
			end
			k++;
		end
		in_valid <= 1'b0;
		while (cost_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0 && cost_q.size() == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

	initial begin
		#200ms;
		$display("tb: done, errors");
		$finish;
	end
endmodule
